FILE: rtl/core/mrq_pkg.sv
package mrq_pkg;

  // Field widths of the request and result channels
  localparam int FUNC_W   = 2;
  localparam int TID_W    = 6;
  localparam int LEVEL_W  = 6;
  localparam int RCPU_W   = 11;
  localparam int NICE_W   = 6;
  localparam int STATUS_W = 2;

  // Defaults of the top level parameters, and the default thread level
  localparam int NUM_THREADS_DEF  = 64;
  localparam int MAX_PRIORITY_DEF = 63;
  localparam int DEFAULT_LEVEL    = 31;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_ENQUEUE   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQUEUE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RECOMPUTE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IDLE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_READY = 2'd2;

endpackage

FILE: rtl/core/mrq_ram.sv
module mrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mrq_prio_calc.sv
module mrq_prio_calc #(
  parameter int MaxPriority = 63
) (
  input  logic signed [mrq_pkg::RCPU_W-1:0]  rcpu_i,
  input  logic signed [mrq_pkg::NICE_W-1:0]  nice_i,
  output logic [$clog2(MaxPriority+1)-1:0]   level_o
);

  localparam int LW = $clog2(MaxPriority + 1);

  logic signed [11:0] rc_ext;
  logic signed [11:0] quot;
  logic signed [11:0] nice_ext;
  logic signed [11:0] prio;

  always_comb begin
    rc_ext   = 12'(rcpu_i);
    nice_ext = 12'(nice_i);
    // divide by four, truncating toward zero
    quot     = (rc_ext + (rc_ext < 0 ? 12'sd3 : 12'sd0)) >>> 2;
    prio     = 12'(MaxPriority) - quot - (nice_ext <<< 1);
    if (prio < 0) begin
      level_o = '0;
    end else if (prio > 12'(MaxPriority)) begin
      level_o = LW'(MaxPriority);
    end else begin
      level_o = prio[LW-1:0];
    end
  end

endmodule

FILE: rtl/core/mrq_level_find.sv
module mrq_level_find #(
  parameter int Levels = 64
) (
  input  logic [Levels-1:0]         nonempty_i,
  output logic [$clog2(Levels)-1:0] level_o,
  output logic                      any_o
);

  localparam int LW = $clog2(Levels);

  always_comb begin
    level_o = '0;
    any_o   = 1'b0;
    for (int i = 0; i < Levels; i++) begin
      if (nonempty_i[i]) begin
        level_o = LW'(i);
        any_o   = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/multilevel_ready_queue_unit.sv
// Multilevel ready queue: FIFO per priority level, highest level served first.
// Enqueue reads level and tail, then appends a thread not yet ready; dequeue reads
// head, then link, and pops (no reads when all queues are empty); recompute rewrites
// the level, and unlinks and re-appends a ready thread that changes level.
// No new request is taken until the sequencer is back in idle; a full output register
// holds the sequencer back. Reset: queues empty, no thread ready; then a sweep writes
// the default level into every thread's level entry, stalling requests.
module multilevel_ready_queue_unit #(
  parameter int NUM_THREADS  = mrq_pkg::NUM_THREADS_DEF,
  parameter int MAX_PRIORITY = mrq_pkg::MAX_PRIORITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mrq_pkg::FUNC_W-1:0]         func_i,
  input  logic [mrq_pkg::TID_W-1:0]          thread_id_i,
  input  logic [mrq_pkg::LEVEL_W-1:0]        new_level_i,
  input  logic signed [mrq_pkg::RCPU_W-1:0]  recent_cpu_int_i,
  input  logic signed [mrq_pkg::NICE_W-1:0]  nice_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mrq_pkg::TID_W-1:0]          out_thread_o,
  output logic [mrq_pkg::LEVEL_W-1:0]        out_level_o,
  output logic [mrq_pkg::STATUS_W-1:0]       status_o
);

  localparam int Levels   = MAX_PRIORITY + 1;
  localparam int TW       = $clog2(NUM_THREADS);
  localparam int LW       = $clog2(Levels);
  localparam int DefLevel = (mrq_pkg::DEFAULT_LEVEL > MAX_PRIORITY) ?
                            MAX_PRIORITY : mrq_pkg::DEFAULT_LEVEL;

  // Sequencer states
  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD0  = 4'd2;
  localparam logic [3:0] ST_ENQ  = 4'd3;
  localparam logic [3:0] ST_DQ1  = 4'd4;
  localparam logic [3:0] ST_DQ2  = 4'd5;
  localparam logic [3:0] ST_RC1  = 4'd6;
  localparam logic [3:0] ST_RC2  = 4'd7;
  localparam logic [3:0] ST_RC3  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  // Reduce a thread id modulo NUM_THREADS, one restoring step per bit
  function automatic logic [TW-1:0] wrap_tid(input logic [mrq_pkg::TID_W-1:0] id);
    logic [16:0] r;
    r = 17'(id);
    for (int k = mrq_pkg::TID_W - 1; k >= 0; k--) begin
      if (r >= (17'(NUM_THREADS) << k)) begin
        r = r - (17'(NUM_THREADS) << k);
      end
    end
    return r[TW-1:0];
  endfunction

  logic [3:0]                     state_q, state_d;
  logic [TW-1:0]                  clr_q, clr_d;
  logic [NUM_THREADS-1:0]         rdy_q, rdy_d;
  logic [Levels-1:0]              ne_q, ne_d;
  logic [mrq_pkg::FUNC_W-1:0]     fn_q, fn_d;
  logic [mrq_pkg::TID_W-1:0]      tid_q, tid_d;
  logic [TW-1:0]                  t_q, t_d;
  logic [LW-1:0]                  lvl_q, lvl_d;
  logic                           any_q, any_d;
  logic [TW-1:0]                  h_q, h_d;
  logic [LW-1:0]                  old_q, old_d;
  logic [mrq_pkg::TID_W-1:0]      res_thread_q, res_thread_d;
  logic [mrq_pkg::LEVEL_W-1:0]    res_level_q, res_level_d;
  logic [mrq_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                           out_valid_q, out_valid_d;
  logic [mrq_pkg::TID_W-1:0]      out_thread_q, out_thread_d;
  logic [mrq_pkg::LEVEL_W-1:0]    out_level_q, out_level_d;
  logic [mrq_pkg::STATUS_W-1:0]   out_status_q, out_status_d;

  logic [LW-1:0] calc_lvl;
  logic [LW-1:0] find_lvl;
  logic          find_any;
  logic [LW-1:0] enq_lvl;
  logic          do_append;

  // Memory ports
  logic          next_we, prev_we, head_we, tail_we, lvl_we;
  logic [TW-1:0] next_wa, next_wd, next_ra, next_rd;
  logic [TW-1:0] prev_wa, prev_wd, prev_ra, prev_rd;
  logic [LW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [TW-1:0] head_wd, head_rd, tail_wd, tail_rd;
  logic [TW-1:0] lvl_wa, lvl_ra;
  logic [LW-1:0] lvl_wd, lvl_rd;

  mrq_prio_calc #(.MaxPriority(MAX_PRIORITY)) u_calc (
    .rcpu_i  (recent_cpu_int_i),
    .nice_i  (nice_value_i),
    .level_o (calc_lvl)
  );

  mrq_level_find #(.Levels(Levels)) u_find (
    .nonempty_i (ne_q),
    .level_o    (find_lvl),
    .any_o      (find_any)
  );

  mrq_ram #(.Width(TW), .Depth(NUM_THREADS)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(next_ra), .rdata_o(next_rd)
  );
  mrq_ram #(.Width(TW), .Depth(NUM_THREADS)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(prev_ra), .rdata_o(prev_rd)
  );
  mrq_ram #(.Width(TW), .Depth(Levels)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );
  mrq_ram #(.Width(TW), .Depth(Levels)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_wa), .wdata_i(tail_wd),
    .raddr_i(tail_ra), .rdata_o(tail_rd)
  );
  mrq_ram #(.Width(LW), .Depth(NUM_THREADS)) u_level (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_wa), .wdata_i(lvl_wd),
    .raddr_i(lvl_ra), .rdata_o(lvl_rd)
  );

  // Saturate the enqueue level to the top priority
  assign enq_lvl = (32'(new_level_i) > MAX_PRIORITY) ? LW'(MAX_PRIORITY) : LW'(new_level_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rdy_d        = rdy_q;
    ne_d         = ne_q;
    fn_d         = fn_q;
    tid_d        = tid_q;
    t_d          = t_q;
    lvl_d        = lvl_q;
    any_d        = any_q;
    h_d          = h_q;
    old_d        = old_q;
    res_thread_d = res_thread_q;
    res_level_d  = res_level_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_thread_d = out_thread_q;
    out_level_d  = out_level_q;
    out_status_d = out_status_q;
    do_append    = 1'b0;

    next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_ra = '0;
    lvl_we  = 1'b0; lvl_wa  = '0; lvl_wd  = '0; lvl_ra  = '0;

    // Drop the result once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        // Sweep the default level into every thread entry
        lvl_we = 1'b1;
        lvl_wa = clr_q;
        lvl_wd = LW'(DefLevel);
        clr_d  = clr_q + 1'b1;
        if (32'(clr_q) == NUM_THREADS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          fn_d  = func_i;
          tid_d = thread_id_i;
          t_d   = wrap_tid(thread_id_i);
          any_d = find_any;
          case (func_i)
            mrq_pkg::FN_ENQUEUE:   lvl_d = enq_lvl;
            mrq_pkg::FN_DEQUEUE:   lvl_d = find_lvl;
            mrq_pkg::FN_RECOMPUTE: lvl_d = calc_lvl;
            default:               lvl_d = '0;
          endcase
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        case (fn_q)
          mrq_pkg::FN_ENQUEUE: begin
            lvl_ra  = t_q;
            tail_ra = lvl_q;
            state_d = ST_ENQ;
          end
          mrq_pkg::FN_DEQUEUE: begin
            if (any_q) begin
              head_ra = lvl_q;
              state_d = ST_DQ1;
            end else begin
              res_thread_d = tid_q;
              res_level_d  = '0;
              res_status_d = mrq_pkg::STAT_IDLE;
              state_d      = ST_DONE;
            end
          end
          mrq_pkg::FN_RECOMPUTE: begin
            lvl_ra  = t_q;
            state_d = ST_RC1;
          end
          default: begin
            res_thread_d = tid_q;
            res_level_d  = '0;
            res_status_d = mrq_pkg::STAT_OK;
            state_d      = ST_DONE;
          end
        endcase
      end
      ST_ENQ: begin
        res_thread_d = tid_q;
        if (rdy_q[t_q]) begin
          res_level_d  = mrq_pkg::LEVEL_W'(lvl_rd);
          res_status_d = mrq_pkg::STAT_READY;
        end else begin
          lvl_we       = 1'b1;
          lvl_wa       = t_q;
          lvl_wd       = lvl_q;
          rdy_d[t_q]   = 1'b1;
          do_append    = 1'b1;
          res_level_d  = mrq_pkg::LEVEL_W'(lvl_q);
          res_status_d = mrq_pkg::STAT_OK;
        end
        state_d = ST_DONE;
      end
      ST_DQ1: begin
        h_d     = head_rd;
        next_ra = head_rd;
        tail_ra = lvl_q;
        state_d = ST_DQ2;
      end
      ST_DQ2: begin
        // Pop the head; the queue empties when head is also the tail
        if (tail_rd == h_q) begin
          ne_d[lvl_q] = 1'b0;
        end else begin
          head_we = 1'b1;
          head_wa = lvl_q;
          head_wd = next_rd;
        end
        rdy_d[h_q]   = 1'b0;
        res_thread_d = mrq_pkg::TID_W'(h_q);
        res_level_d  = mrq_pkg::LEVEL_W'(lvl_q);
        res_status_d = mrq_pkg::STAT_OK;
        state_d      = ST_DONE;
      end
      ST_RC1: begin
        old_d  = lvl_rd;
        lvl_we = 1'b1;
        lvl_wa = t_q;
        lvl_wd = lvl_q;
        res_thread_d = tid_q;
        res_level_d  = mrq_pkg::LEVEL_W'(lvl_q);
        res_status_d = mrq_pkg::STAT_OK;
        if (rdy_q[t_q] && (lvl_rd != lvl_q)) begin
          head_ra = lvl_rd;
          tail_ra = lvl_rd;
          next_ra = t_q;
          prev_ra = t_q;
          state_d = ST_RC2;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RC2: begin
        // Unlink the thread from its old queue
        if ((head_rd == t_q) && (tail_rd == t_q)) begin
          ne_d[old_q] = 1'b0;
        end else begin
          if (head_rd == t_q) begin
            head_we = 1'b1;
            head_wa = old_q;
            head_wd = next_rd;
          end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
          end
          if (tail_rd == t_q) begin
            tail_we = 1'b1;
            tail_wa = old_q;
            tail_wd = prev_rd;
          end else begin
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
          end
        end
        tail_ra = lvl_q;
        state_d = ST_RC3;
      end
      ST_RC3: begin
        do_append = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_thread_d = res_thread_q;
          out_level_d  = res_level_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Append thread t_q at the tail of queue lvl_q, tail read in the cycle before
    if (do_append) begin
      tail_we = 1'b1;
      tail_wa = lvl_q;
      tail_wd = t_q;
      if (ne_q[lvl_q]) begin
        next_we = 1'b1;
        next_wa = tail_rd;
        next_wd = t_q;
        prev_we = 1'b1;
        prev_wa = t_q;
        prev_wd = tail_rd;
      end else begin
        head_we     = 1'b1;
        head_wa     = lvl_q;
        head_wd     = t_q;
        ne_d[lvl_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      rdy_q       <= '0;
      ne_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rdy_q       <= rdy_d;
      ne_q        <= ne_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q         <= fn_d;
    tid_q        <= tid_d;
    t_q          <= t_d;
    lvl_q        <= lvl_d;
    any_q        <= any_d;
    h_q          <= h_d;
    old_q        <= old_d;
    res_thread_q <= res_thread_d;
    res_level_q  <= res_level_d;
    res_status_q <= res_status_d;
    out_thread_q <= out_thread_d;
    out_level_q  <= out_level_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_thread_o = out_thread_q;
  assign out_level_o  = out_level_q;
  assign status_o     = out_status_q;

  // No more levels are nonempty than threads are ready
  a_ne_le_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(ne_q) <= $countones(rdy_q))
    else $error("nonempty levels exceed ready threads");

  // No ready thread means no queue holds anything
  a_no_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(rdy_q) == 0) |-> (ne_q == '0))
    else $error("queue nonempty with no ready thread");

  // A pop always targets a level that holds a thread
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DQ2) |-> ne_q[lvl_q])
    else $error("pop from empty level");

  // An idle report carries level zero
  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == mrq_pkg::STAT_IDLE)) |-> (out_level_o == '0))
    else $error("idle result with nonzero level");

endmodule
